// ----- rtl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the stream substring replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 4;
    localparam int LIMIT_W    = 17;
    localparam int DONE_W     = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_REPLACE_LIMIT      = 3'd4
    } cfg_reg_t;

    // Control info for one burst of result bytes
    typedef struct packed {
        logic [LEN_W-1:0] count;   // bytes in burst, 1..burst depth
        logic             marker;  // empty end-of-stream marker
        logic             last;    // burst closes the stream
    } burst_ctl_t;

endpackage

// ----- rtl/ssr_burst_buf.sv -----
// ----------------------------------------------------------------------------
// ssr_burst_buf
// Holds one burst of result bytes and sends them out one per transaction.
// ----------------------------------------------------------------------------
module ssr_burst_buf
    import ssr_pkg::*;
#(
    parameter int BURST = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [BURST-1:0][BYTE_W-1:0] load_bytes,
    input  burst_ctl_t                   load_ctl,
    output logic                         load_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [BYTE_W-1:0]            m_tdata,   // [7:0] out_byte
    output logic                         m_tuser,   // [0] out_valid
    output logic                         m_tlast
);

    localparam int IDX_W = (BURST > 1) ? $clog2(BURST) : 1;

    logic [BURST-1:0][BYTE_W-1:0] bytes_reg;
    burst_ctl_t                   ctl_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         busy_reg;
    logic                         at_end;
    logic                         finish;

    assign at_end     = (LEN_W'(idx_reg) == ctl_reg.count - 1'b1);
    assign finish     = busy_reg && m_tready && at_end;
    assign load_ready = !busy_reg || finish;

    assign m_tvalid = busy_reg;
    assign m_tdata  = ctl_reg.marker ? '0 : bytes_reg[idx_reg];
    assign m_tuser  = !ctl_reg.marker;
    assign m_tlast  = ctl_reg.last && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ctl_reg  <= '0;
        end else if (load) begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            ctl_reg   <= load_ctl;
            bytes_reg <= load_bytes;
        end else if (busy_reg && m_tready) begin
            if (at_end) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
        end
    end

endmodule

// ----- rtl/stream_substring_replace.sv -----
// ----------------------------------------------------------------------------
// stream_substring_replace
// Byte stream search and replace with a configurable pattern and replacement.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one source byte per transaction, s_tlast on the final
//   byte of a stream. m_ channel returns the edited text, one byte per
//   transaction; m_tuser low marks an empty end marker (data zero) sent when
//   the final input byte produces no text. m_tlast closes each stream.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Timing:
//   An accepted byte lands in the input register; the window compare runs
//   on it and its result burst (0 to max(PATTERN_MAX, REPLACEMENT_MAX) bytes)
//   is loaded into the burst buffer once the buffer can take it. One input
//   byte is taken per cycle as long as each burst is at most one byte and
//   the receiver takes every result byte; a burst of n bytes holds the
//   output port until all n bytes are taken, and the input side stalls
//   behind it once the input register is full.
// Reset:
//   aresetn empties the window and both buffers and clears the replacement
//   counter and configuration (limit reads as unlimited). A stalled receiver
//   holds its current byte stable; at most one more input byte is taken.
// ----------------------------------------------------------------------------
module stream_substring_replace
    import ssr_pkg::*;
#(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                  m_tuser,   // [0] out_valid
    output logic                  m_tlast
);

    localparam int BURST = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
    localparam logic [LEN_W-1:0] PAT_MAX_L = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] REP_MAX_L = LEN_W'(REPLACEMENT_MAX);

    // configuration
    logic [CFG_DATA_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0]      rep_len_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // search state
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_reg, win_next, win_app;
    logic [LEN_W-1:0]                   cnt_reg, cnt_next, cnt_app;
    logic [DONE_W-1:0]                  done_reg, done_next;

    logic [LEN_W-1:0]             len, rlen, n_out, shift;
    logic                         match, allow, do_rep;
    logic [BURST-1:0][BYTE_W-1:0] burst_bytes;
    burst_ctl_t                   burst_ctl;
    logic                         buf_ready;
    logic                         advance;

    assign advance  = in_vld_reg && buf_ready;
    assign s_tready = !in_vld_reg || buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            limit_reg     <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:      pat_bytes_reg <= cfg_wdata;
                REG_PATTERN_LENGTH:     pat_len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_wdata;
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_REPLACE_LIMIT:      limit_reg     <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_comb begin
        len  = (pat_len_reg > PAT_MAX_L) ? PAT_MAX_L : pat_len_reg;
        rlen = (rep_len_reg > REP_MAX_L) ? REP_MAX_L : rep_len_reg;

        // append the new byte behind the pending ones
        cnt_app = cnt_reg + 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_app[i] = (cnt_reg == LEN_W'(i)) ? in_byte_reg : win_reg[i];
        end

        match = (len != '0) && (cnt_app == len);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i) < len && win_app[i] != pat_bytes_reg[BYTE_W*i +: BYTE_W]) begin
                match = 1'b0;
            end
        end
        allow  = limit_reg[LIMIT_W-1] || (done_reg < limit_reg[DONE_W-1:0]);
        do_rep = allow && match;

        shift     = '0;
        cnt_next  = '0;
        done_next = done_reg;
        if (do_rep) begin
            n_out = rlen;
            if (done_reg != '1) begin
                done_next = done_reg + 1'b1;
            end
        end else if (in_last_reg) begin
            n_out = cnt_app;
        end else if (len != '0 && cnt_app == len) begin
            n_out    = LEN_W'(1);
            shift    = LEN_W'(1);
            cnt_next = cnt_app - 1'b1;
        end else if (cnt_app > len) begin
            n_out    = (cnt_app >= LEN_W'(2)) ? LEN_W'(2) : LEN_W'(1);
            shift    = n_out;
            cnt_next = cnt_app - n_out;
        end else begin
            n_out    = '0;
            cnt_next = cnt_app;
        end

        // drop the bytes that went out
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_next[i] = win_app[i];
            if (shift == LEN_W'(1) && i + 1 < PATTERN_MAX) begin
                win_next[i] = win_app[i+1];
            end else if (shift == LEN_W'(2) && i + 2 < PATTERN_MAX) begin
                win_next[i] = win_app[i+2];
            end
        end

        if (in_last_reg) begin
            cnt_next  = '0;
            done_next = '0;
        end

        for (int j = 0; j < BURST; j++) begin
            if (do_rep) begin
                burst_bytes[j] = rep_bytes_reg[BYTE_W*j +: BYTE_W];
            end else if (j < PATTERN_MAX) begin
                burst_bytes[j] = win_app[j];
            end else begin
                burst_bytes[j] = '0;
            end
        end

        burst_ctl.marker = in_last_reg && (n_out == '0);
        burst_ctl.count  = burst_ctl.marker ? LEN_W'(1) : n_out;
        burst_ctl.last   = in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= '0;
        end else if (advance) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        if (advance) begin
            win_reg <= win_next;
        end
    end

    ssr_burst_buf #(
        .BURST (BURST)
    ) u_burst_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && burst_ctl.count != '0),
        .load_bytes (burst_bytes),
        .load_ctl   (burst_ctl),
        .load_ready (buf_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- rtl/ssr_checker.sv -----
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks for stream_substring_replace, bound to the top level.
// ----------------------------------------------------------------------------
module ssr_checker
    import ssr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    // hold a stalled result transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty marker closes the stream and carries zero data
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
        else $error("malformed end marker");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);

// ----- tb/ssr_text_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssr_text_checker
// Watches both stream channels and the register port of the substring
// replace block, predicts the edited text of every source byte and compares
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ssr_text_checker
    import ssr_pkg::*;
#(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [BYTE_W-1:0]     m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    failures,
    output int                    outstanding
);

    localparam int WIN_DEPTH = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } text_item_t;

    // Shadow copy of the register file
    logic [CFG_DATA_W-1:0] pat_bytes;
    logic [LEN_W-1:0]      pat_len_r;
    logic [CFG_DATA_W-1:0] rep_bytes;
    logic [LEN_W-1:0]      rep_len_r;
    logic [LIMIT_W-1:0]    limit_r;

    // Shadow copy of the search state
    logic [BYTE_W-1:0] window [WIN_DEPTH];
    int                win_count;
    logic [DONE_W-1:0] matches_done;

    text_item_t expected_text[$];
    text_item_t want;
    int         step_n;
    int         fails;

    initial begin
        failures    = 0;
        outstanding = 0;
        fails       = 0;
    end

    // Emit the oldest pending byte and shift the window down.
    task shift_out();
        if (win_count != 0) begin
            expected_text.push_back(text_item_t'({window[0], 1'b1, 1'b0}));
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                window[i] = window[i + 1];
            win_count = win_count - 1;
            step_n    = step_n + 1;
        end
    endtask

    task predict_text(input logic [BYTE_W-1:0] b, input logic is_last);
        int   plen;
        int   rlen;
        logic hit;
        plen   = (pat_len_r > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_r);
        rlen   = (rep_len_r > REPLACEMENT_MAX) ? REPLACEMENT_MAX : int'(rep_len_r);
        step_n = 0;
        if (win_count < WIN_DEPTH) begin
            window[win_count] = b;
            win_count         = win_count + 1;
        end
        hit = (plen != 0) && (win_count == plen);
        if (hit) begin
            for (int i = 0; i < plen; i++)
                if (window[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
        end
        if (hit && (limit_r[LIMIT_W-1] || (matches_done < limit_r[DONE_W-1:0]))) begin
            for (int i = 0; i < rlen; i++) begin
                expected_text.push_back(text_item_t'({rep_bytes[8*i +: 8], 1'b1, 1'b0}));
                step_n = step_n + 1;
            end
            win_count = 0;
            if (matches_done != '1)
                matches_done = matches_done + 1'b1;
        end else if (is_last) begin
            while (win_count > 0)
                shift_out();
        end else if ((plen > 0) && (win_count == plen)) begin
            shift_out();
        end else if (win_count > plen) begin
            // window longer than the pattern: drain up to two per byte
            shift_out();
            shift_out();
        end
        if (is_last) begin
            if (step_n == 0)
                expected_text.push_back(text_item_t'({8'h00, 1'b0, 1'b0}));
            expected_text[expected_text.size() - 1].last = 1'b1;
            win_count    = 0;
            matches_done = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes    = '0;
            pat_len_r    = '0;
            rep_bytes    = '0;
            rep_len_r    = '0;
            limit_r      = '1;
            win_count    = 0;
            matches_done = '0;
            for (int i = 0; i < WIN_DEPTH; i++)
                window[i] = '0;
            expected_text.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected result transaction: out_byte %02h out_valid %0b out_last %0b",
                           m_tdata, m_tuser, m_tlast);
                    fails = fails + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte mismatch: expected %02h, got %02h", want.data, m_tdata);
                        fails = fails + 1;
                    end
                    if (m_tuser !== want.valid) begin
                        $error("out_valid mismatch: expected %0b, got %0b", want.valid, m_tuser);
                        fails = fails + 1;
                    end
                    if (m_tlast !== want.last) begin
                        $error("out_last mismatch: expected %0b, got %0b", want.last, m_tlast);
                        fails = fails + 1;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PATTERN_BYTES:      pat_bytes = cfg_wdata;
                    REG_PATTERN_LENGTH:     pat_len_r = cfg_wdata[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES:  rep_bytes = cfg_wdata;
                    REG_REPLACEMENT_LENGTH: rep_len_r = cfg_wdata[LEN_W-1:0];
                    REG_REPLACE_LIMIT:      limit_r   = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_text(s_tdata, s_tlast);
        end
        failures    <= fails;
        outstanding <= expected_text.size();
    end

endmodule

// ----- tb/stream_substring_replace_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_substring_replace_tb
// Drives source text streams through the substring replace block under a
// series of register settings, with random gaps on the source side and
// random back-pressure on the result side; the checker beside the block
// predicts and compares every result byte.
// ----------------------------------------------------------------------------
module stream_substring_replace_tb;
    import ssr_pkg::*;

    localparam int             PATTERN_MAX     = 8;
    localparam int             REPLACEMENT_MAX = 8;
    localparam int             RANDOM_ITEMS    = 335;
    localparam int             CYCLE_LIMIT     = 1_000_000;
    localparam logic [LIMIT_W-1:0] NO_LIMIT    = '1;
    localparam logic [BYTE_W-1:0]  CH_A        = 8'h61;
    localparam logic [BYTE_W-1:0]  CH_B        = 8'h62;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit steady      = 1'b0;

    // Settings currently loaded, used to shape the text
    logic [CFG_DATA_W-1:0] cur_pat;
    logic [LEN_W-1:0]      cur_plen;
    logic [CFG_DATA_W-1:0] cur_rep;
    logic [LEN_W-1:0]      cur_rlen;
    logic [LIMIT_W-1:0]    cur_limit;

    always #4 aclk = ~aclk;

    stream_substring_replace #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ssr_text_checker #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    ) text_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= pause_len();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Hold the source side idle until every predicted byte is out, then let
    // the last accepted byte clear the pipeline.
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task load_settings(input logic [CFG_DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
                       input logic [CFG_DATA_W-1:0] rep, input logic [LEN_W-1:0] rlen,
                       input logic [LIMIT_W-1:0] limit);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_wdata <= pat;
        @(posedge aclk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_wdata <= CFG_DATA_W'(plen);
        @(posedge aclk);
        cfg_index <= REG_REPLACEMENT_BYTES;
        cfg_wdata <= rep;
        @(posedge aclk);
        cfg_index <= REG_REPLACEMENT_LENGTH;
        cfg_wdata <= CFG_DATA_W'(rlen);
        @(posedge aclk);
        cfg_index <= REG_REPLACE_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_pat   = pat;
        cur_plen  = plen;
        cur_rep   = rep;
        cur_rlen  = rlen;
        cur_limit = limit;
    endtask

    task send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task send_text(input logic [BYTE_W-1:0] text[$], input bit close);
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], close && (i == text.size() - 1));
    endtask

    task random_settings();
        logic [CFG_DATA_W-1:0] pat;
        logic [LEN_W-1:0]      plen;
        logic [LEN_W-1:0]      rlen;
        logic [LIMIT_W-1:0]    limit;
        int                    r;
        // draw pattern bytes mostly from a tiny alphabet so matches happen
        for (int i = 0; i < 8; i++)
            pat[8*i +: 8] = ($urandom_range(0, 3) != 0) ? BYTE_W'(CH_A + $urandom_range(0, 2))
                                                         : BYTE_W'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            plen = '0;
        else if (r < 7)
            plen = LEN_W'($urandom_range(1, 4));
        else if (r < 9)
            plen = LEN_W'($urandom_range(5, 8));
        else
            plen = LEN_W'($urandom_range(9, 15));
        rlen = ($urandom_range(0, 9) < 8) ? LEN_W'($urandom_range(0, 4))
                                          : LEN_W'($urandom_range(5, 15));
        r = $urandom_range(0, 9);
        if (r < 6)
            limit = NO_LIMIT;
        else if (r < 8)
            limit = LIMIT_W'($urandom_range(0, 3));
        else if (r == 8)
            limit = 17'd65535;
        else
            limit = LIMIT_W'($urandom_range(0, 65535));
        load_settings(pat, plen, {$urandom, $urandom}, rlen, limit);
    endtask

    task random_stream(inout int items);
        logic [BYTE_W-1:0] text[$];
        int                n;
        int                pl;
        int                cut;
        int                split;
        int                r;
        text.delete();
        n  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
        pl = (cur_plen > PATTERN_MAX) ? PATTERN_MAX : int'(cur_plen);
        while (text.size() < n) begin
            r = $urandom_range(0, 9);
            if (r < 4 && pl > 0) begin
                // whole pattern, or a prefix of it as a near miss
                cut = (r == 3) ? $urandom_range(1, pl) : pl;
                for (int j = 0; j < cut; j++)
                    text.push_back(cur_pat[8*j +: 8]);
            end else if (r < 8) begin
                text.push_back(BYTE_W'(CH_A + $urandom_range(0, 2)));
            end else begin
                text.push_back(BYTE_W'($urandom));
            end
        end
        while (text.size() > n)
            void'(text.pop_back());
        split = ($urandom_range(0, 7) == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < n; i++) begin
            if (i == split)
                load_settings(cur_pat, LEN_W'($urandom_range(0, pl)), cur_rep, cur_rlen,
                              cur_limit);
            send_byte(text[i], i == n - 1);
            items = items + 1;
        end
    endtask

    initial begin
        int random_items;
        random_items = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: empty pattern, text passes through
        send_text('{8'h00, 8'hFF}, 1'b1);

        load_settings({48'h0, CH_B, CH_A}, 4'd2, 64'h5A5958, 4'd3, NO_LIMIT);
        send_text('{CH_A, CH_B}, 1'b1);
        send_text('{8'h78, CH_A, CH_B, CH_A, CH_A, CH_B, 8'h79}, 1'b1);

        // Deleting replacement: a stream reduced to nothing ends in a marker
        load_settings({48'h0, CH_B, CH_A}, 4'd2, 64'h5A5958, 4'd0, NO_LIMIT);
        send_text('{CH_A, CH_B}, 1'b1);

        load_settings({48'h0, CH_B, CH_A}, 4'd2, 64'h5A5958, 4'd3, 17'd1);
        send_text('{CH_A, CH_B, CH_A, CH_B}, 1'b1);
        load_settings({48'h0, CH_B, CH_A}, 4'd2, 64'h5A5958, 4'd3, 17'd0);
        send_text('{CH_A, CH_B}, 1'b1);

        // Oversized lengths clamp to the maximum
        load_settings('1, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd12, 17'd65535);
        send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_text('{8'h00}, 1'b1);

        // Shrink the pattern, then empty it, while bytes are pending
        load_settings('0, 4'd8, 64'h21, 4'd1, NO_LIMIT);
        send_text('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
        load_settings('0, 4'd2, 64'h21, 4'd1, NO_LIMIT);
        send_text('{8'h11}, 1'b0);
        load_settings('0, 4'd0, 64'h21, 4'd1, NO_LIMIT);
        send_text('{8'h22}, 1'b1);

        while (random_items < RANDOM_ITEMS) begin
            random_settings();
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 5)) begin
                if (random_items < RANDOM_ITEMS)
                    random_stream(random_items);
            end
        end
        steady = 1'b0;

        settle();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
